// ===== hw/rtl/ftt_pkg.sv =====
// ----------------------------------------------------------------------------
// Folder tree table package
// Shared sizes, codes and payload types of the folder tree table.
// ----------------------------------------------------------------------------
`default_nettype none

package ftt_pkg;

  // Table size and derived widths.
  localparam int MAX_NODES = 32;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  // Flag bit positions.
  localparam int FLAG_SEL  = 0;
  localparam int FLAG_DIR  = 1;
  localparam int FLAG_OPEN = 2;

  localparam logic [31:0] HANDLE_RESET = 32'd55;
  localparam logic [4:0]  DEPTH_TOP    = 5'd31;
  localparam logic [4:0]  COUNT_TOP    = 5'd31;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_EMPTY  = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_OPEN   = 3'd4,
    OP_SELECT = 3'd5,
    OP_COUNT  = 3'd6,
    OP_NTH    = 3'd7
  } ftt_op_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [31:0] handle;
    logic [4:0]  depth;
    logic [2:0]  flags;
  } ftt_entry_t;

  localparam int ENTRY_W = $bits(ftt_entry_t);

  // Request payload.
  typedef struct packed {
    ftt_op_t     op;
    logic [31:0] target_handle;
    logic [2:0]  node_flags_in;
    logic        flag_value;
    logic [4:0]  position;
  } ftt_in_t;

  // Result payload.
  typedef struct packed {
    logic        ok;
    logic [31:0] found_handle;
    logic [4:0]  visible_count;
  } ftt_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ftt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ftt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/folder_tree_table.sv =====
// ----------------------------------------------------------------------------
// Folder tree table
// Pre-order folder tree kept in one entry memory, driven by a sequencer.
// ----------------------------------------------------------------------------
// Channel   Ports                      Transfer
// request   start, busy, in_req        start high while busy is low
// result    out_valid, out_res         out_valid high for one cycle
//
// Init and empty finish straight from idle. Other operations first look the handle
// up entry by entry (memory read, then compare). The add shift and the subtree
// end scan then read each entry and then write or check it, while gap closing, the
// flag pass and the visible walk step through loop test, read, then check or write.
// The single memory read port makes every pass handle one entry at a time.
// Reset is synchronous and active low; the table starts empty with no clearing
// pass. The result appears the cycle after the request finishes and cannot be
// stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module folder_tree_table
  import ftt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire ftt_in_t in_req,
  output logic         out_valid,
  output ftt_out_t     out_res
);

  typedef enum logic [4:0] {
    IDLE, LOC_RD, LOC_CHK, DISPATCH, SHIFT_RD, SHIFT_WR, ADD_NEW,
    END_RD, END_CHK, COPY_TEST, COPY_RD, COPY_WR,
    OPEN_TEST, OPEN_RD, OPEN_CHK, WALK_TEST, WALK_RD, WALK_CHK
  } state_t;

  state_t             state_r, state_nxt;
  ftt_in_t            req_r, req_nxt;
  ftt_entry_t         idw_r, idw_nxt;
  logic [IDX_W-1:0]   id_r, id_nxt;
  logic [IDX_W-1:0]   dst_r, dst_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [5:0]         skip_r, skip_nxt;
  logic               skipping_r, skipping_nxt;
  logic [31:0]        next_handle_r, next_handle_nxt;
  logic               out_valid_r, out_valid_nxt;
  ftt_out_t           out_res_r, out_res_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  ftt_entry_t         wdata;
  ftt_entry_t         rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic [31:0]        nh_inc;
  logic               fin;
  ftt_out_t           res;
  logic [CNT_W-1:0]   id_up;
  logic               isdir, isopen;
  ftt_entry_t         id_upd;

  // Entry memory.
  ftt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NODES)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(i_r[IDX_W-1:0]),
    .rdata(rdata_raw)
  );
  assign rdata = ftt_entry_t'(rdata_raw);

  // Next handle, skipping zero on wrap.
  assign nh_inc = (next_handle_r + 32'd1 == 32'd0) ? 32'd1 : next_handle_r + 32'd1;
  assign id_up  = CNT_W'(id_r) + CNT_W'(1);
  assign isdir  = idw_r.flags[FLAG_DIR];
  assign isopen = idw_r.flags[FLAG_OPEN];

  // Target entry with the open or selected flag updated.
  always_comb begin
    id_upd = idw_r;
    if (req_r.op == OP_SELECT) begin
      id_upd.flags[FLAG_SEL] = req_r.flag_value;
    end else begin
      id_upd.flags[FLAG_OPEN] = req_r.flag_value;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    idw_nxt         = idw_r;
    id_nxt          = id_r;
    dst_nxt         = dst_r;
    i_nxt           = i_r;
    used_nxt        = used_r;
    cnt_nxt         = cnt_r;
    skip_nxt        = skip_r;
    skipping_nxt    = skipping_r;
    next_handle_nxt = next_handle_r;
    out_res_nxt     = out_res_r;
    we              = 1'b0;
    waddr           = id_r;
    wdata           = id_upd;
    fin             = 1'b0;
    res             = '0;

    unique case (state_r)
      IDLE: begin
        if (start) begin
          req_nxt      = in_req;
          i_nxt        = '0;
          cnt_nxt      = '0;
          skipping_nxt = 1'b0;
          priority if (in_req.op == OP_INIT) begin
            we              = 1'b1;
            waddr           = '0;
            wdata.handle    = nh_inc;
            wdata.depth     = '0;
            wdata.flags     = in_req.node_flags_in | 3'(1 << FLAG_DIR);
            next_handle_nxt = nh_inc;
            used_nxt        = CNT_W'(1);
            fin             = 1'b1;
            res.ok          = 1'b1;
            res.found_handle = nh_inc;
          end else if (in_req.op == OP_EMPTY) begin
            used_nxt = CNT_W'(1);
            fin      = 1'b1;
            res.ok   = 1'b1;
          end else if (in_req.target_handle == 32'd0 || used_r == '0) begin
            fin = 1'b1;
          end else begin
            state_nxt = LOC_RD;
          end
        end
      end

      // Linear handle search.
      LOC_RD: state_nxt = LOC_CHK;
      LOC_CHK: begin
        if (rdata.handle == req_r.target_handle) begin
          id_nxt    = i_r[IDX_W-1:0];
          idw_nxt   = rdata;
          state_nxt = DISPATCH;
        end else if (i_r + CNT_W'(1) < used_r) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = LOC_RD;
        end else begin
          fin = 1'b1;
        end
      end

      // Start the per-operation pass on the found entry.
      DISPATCH: begin
        unique case (req_r.op)
          OP_ADD: begin
            if (isdir && used_r < CNT_W'(MAX_NODES) && idw_r.depth < DEPTH_TOP) begin
              if (used_r > id_up) begin
                i_nxt     = used_r - CNT_W'(1);
                state_nxt = SHIFT_RD;
              end else begin
                state_nxt = ADD_NEW;
              end
            end else begin
              fin = 1'b1;
            end
          end
          OP_REMOVE: begin
            i_nxt   = id_up;
            dst_nxt = id_r;
            if (isdir && id_up < used_r) begin
              state_nxt = END_RD;
            end else begin
              state_nxt = COPY_TEST;
            end
          end
          OP_OPEN: begin
            if (isdir) begin
              i_nxt     = id_up;
              state_nxt = OPEN_TEST;
            end else begin
              fin = 1'b1;
            end
          end
          OP_SELECT: begin
            we     = 1'b1;
            fin    = 1'b1;
            res.ok = 1'b1;
          end
          OP_COUNT: begin
            if (isdir && isopen) begin
              i_nxt     = id_up;
              state_nxt = WALK_TEST;
            end else begin
              fin    = 1'b1;
              res.ok = isdir;
            end
          end
          OP_NTH: begin
            if (isdir && isopen) begin
              i_nxt     = id_up;
              state_nxt = WALK_TEST;
            end else begin
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
      end

      // Shift later entries up by one to open a slot after the parent.
      SHIFT_RD: state_nxt = SHIFT_WR;
      SHIFT_WR: begin
        we    = 1'b1;
        waddr = IDX_W'(i_r + CNT_W'(1));
        wdata = rdata;
        if (i_r > id_up) begin
          i_nxt     = i_r - CNT_W'(1);
          state_nxt = SHIFT_RD;
        end else begin
          state_nxt = ADD_NEW;
        end
      end
      ADD_NEW: begin
        we              = 1'b1;
        waddr           = IDX_W'(id_up);
        wdata.handle    = nh_inc;
        wdata.depth     = idw_r.depth + 5'd1;
        wdata.flags     = req_r.node_flags_in;
        next_handle_nxt = nh_inc;
        used_nxt        = used_r + CNT_W'(1);
        fin             = 1'b1;
        res.ok          = 1'b1;
        res.found_handle = nh_inc;
      end

      // Find the end of the removed subtree.
      END_RD: state_nxt = END_CHK;
      END_CHK: begin
        if (rdata.depth > idw_r.depth) begin
          i_nxt = i_r + CNT_W'(1);
          if (i_r + CNT_W'(1) < used_r) begin
            state_nxt = END_RD;
          end else begin
            state_nxt = COPY_TEST;
          end
        end else begin
          state_nxt = COPY_TEST;
        end
      end

      // Close the gap by copying entries down.
      COPY_TEST: begin
        if (i_r < used_r) begin
          state_nxt = COPY_RD;
        end else begin
          used_nxt = CNT_W'(dst_r);
          fin      = 1'b1;
          res.ok   = 1'b1;
        end
      end
      COPY_RD: state_nxt = COPY_WR;
      COPY_WR: begin
        we        = 1'b1;
        waddr     = dst_r;
        wdata     = rdata;
        i_nxt     = i_r + CNT_W'(1);
        dst_nxt   = dst_r + IDX_W'(1);
        state_nxt = COPY_TEST;
      end

      // Set or clear the open flag of every folder in the subtree.
      OPEN_TEST: begin
        if (i_r < used_r) begin
          state_nxt = OPEN_RD;
        end else begin
          we     = 1'b1;
          fin    = 1'b1;
          res.ok = 1'b1;
        end
      end
      OPEN_RD: state_nxt = OPEN_CHK;
      OPEN_CHK: begin
        if (rdata.depth > idw_r.depth) begin
          we                     = rdata.flags[FLAG_DIR];
          waddr                  = i_r[IDX_W-1:0];
          wdata                  = rdata;
          wdata.flags[FLAG_OPEN] = req_r.flag_value;
          i_nxt                  = i_r + CNT_W'(1);
          state_nxt              = OPEN_TEST;
        end else begin
          we     = 1'b1;
          fin    = 1'b1;
          res.ok = 1'b1;
        end
      end

      // Walk the visible descendants, skipping closed folders.
      WALK_TEST: begin
        if (i_r < used_r) begin
          state_nxt = WALK_RD;
        end else begin
          fin    = 1'b1;
          res.ok = 1'b1;
          if (req_r.op == OP_COUNT) begin
            res.visible_count = (32'(cnt_r) > 32'(COUNT_TOP)) ? COUNT_TOP : 5'(cnt_r);
          end
        end
      end
      WALK_RD: state_nxt = WALK_CHK;
      WALK_CHK: begin
        priority if (rdata.depth <= idw_r.depth) begin
          fin    = 1'b1;
          res.ok = 1'b1;
          if (req_r.op == OP_COUNT) begin
            res.visible_count = (32'(cnt_r) > 32'(COUNT_TOP)) ? COUNT_TOP : 5'(cnt_r);
          end
        end else if (skipping_r && 6'(rdata.depth) >= skip_r) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = WALK_TEST;
        end else begin
          if (rdata.flags[FLAG_DIR]) begin
            skipping_nxt = !rdata.flags[FLAG_OPEN];
            skip_nxt     = 6'(rdata.depth) + 6'd1;
          end
          if (req_r.op == OP_NTH && 32'(cnt_r) == 32'(req_r.position)) begin
            fin              = 1'b1;
            res.ok           = 1'b1;
            res.found_handle = rdata.handle;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = WALK_TEST;
          end
        end
      end

      default: state_nxt = IDLE;
    endcase

    out_valid_nxt = fin;
    if (fin) begin
      out_res_nxt = res;
      state_nxt   = IDLE;
    end
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= IDLE;
      used_r        <= '0;
      next_handle_r <= HANDLE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      used_r        <= used_nxt;
      next_handle_r <= next_handle_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    idw_r      <= idw_nxt;
    id_r       <= id_nxt;
    dst_r      <= dst_nxt;
    i_r        <= i_nxt;
    cnt_r      <= cnt_nxt;
    skip_r     <= skip_nxt;
    skipping_r <= skipping_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign busy      = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  // A result is only shown once the sequencer is back at rest.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // The fill count never exceeds the table.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(MAX_NODES)) else $error("used entries overflow");

  // An accepted request either finishes at once or keeps the block busy.
  a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy)) else $error("request lost");

  // A rejected request reports neither a handle nor a count.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.ok) |-> (out_res.found_handle == 32'd0 &&
    out_res.visible_count == 5'd0)) else $error("rejected result not clean");
`endif

endmodule

`default_nettype wire
